// ===== rtl/mtts_pkg.sv =====
// Shared types, constants and elaboration-time table builders for the 2-3-2 sigmoid MLP.
package mtts_pkg;

   // Field and register geometry
   localparam int READING_W     = 8;
   localparam int DRIVE_W       = 8;
   localparam int FIELD_W       = 16;
   localparam int INPUT_COUNT   = 2;
   localparam int HIDDEN_COUNT  = 3;
   localparam int OUTPUT_COUNT  = 2;
   localparam int HID_REG_W     = FIELD_W * (INPUT_COUNT + 1);
   localparam int OUT_REG_W     = FIELD_W * (HIDDEN_COUNT + 1);
   localparam int CSR_DATA_W    = OUT_REG_W;
   localparam int CSR_IDX_W     = 3;

   // Accumulator bits added on top of the weight fraction bits
   localparam int ACC_GUARD     = 19;

   // Normalization and output scaling
   localparam int NORM_FULL_SCALE = 100;
   localparam int NORM_IDX_W      = 7;
   localparam int DRIVE_MAX       = 255;

   // Sigmoid table construction
   localparam int          EXP_FRAC       = 30;
   localparam int          EXP_TERMS      = 12;
   localparam int          EXP_SQUARINGS  = 4;
   localparam int          EXP_PRE_SHIFT  = 4;
   localparam int          SIG_HALF_RANGE = 8;
   localparam int          SIG_VAL_W      = 16;
   localparam logic [63:0] EXP_ONE        = 64'd1 << EXP_FRAC;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_HIDDEN_ONE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIDDEN_TWO   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIDDEN_THREE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LEFT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_RIGHT    = 3'd4;

   // Pipeline stage numbering
   localparam int STAGES       = 10;
   localparam int STG_NORM     = 0;
   localparam int STG_HID_PROD = 1;
   localparam int STG_HID_ACC  = 2;
   localparam int STG_HID_IDX  = 3;
   localparam int STG_HID_ROM  = 4;
   localparam int STG_OUT_PROD = 5;
   localparam int STG_OUT_ACC  = 6;
   localparam int STG_OUT_IDX  = 7;
   localparam int STG_OUT_ROM  = 8;
   localparam int STG_DRIVE    = 9;

   typedef struct packed {
      logic [READING_W-1:0] left_reading;
      logic [READING_W-1:0] right_reading;
   } req_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] left_drive;
      logic [DRIVE_W-1:0] right_drive;
   } rsp_type;

   typedef struct packed {
      logic [STAGES-1:0] en;
      logic [STAGES-1:0] vld;
   } pipe_ctrl_type;

   typedef struct packed {
      logic idx_en;
      logic rom_en;
   } sig_en_type;

   // Restoring shift-subtract division, used only while building tables
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^-a in Q1.30: series on a/16, then square four times
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] prod;
      y    = a >> EXP_PRE_SHIFT;
      term = EXP_ONE;
      sum  = EXP_ONE;
      for (int k = 1; k <= EXP_TERMS; k++) begin
         prod = (term * y) >> EXP_FRAC;
         term = udiv64(prod, 64'(k));
         if (k[0]) begin
            sum = (sum >= term) ? sum - term : '0;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > EXP_ONE) begin
         sum = EXP_ONE;
      end
      for (int s = 0; s < EXP_SQUARINGS; s++) begin
         sum = (sum * sum) >> EXP_FRAC;
      end
      return sum;
   endfunction

   // Sigmoid at the center of bin i, rounded to nearest with frac_bits fraction bits
   function automatic logic [SIG_VAL_W-1:0] sigmoid_entry(input int entries,
                                                           input int frac_bits,
                                                           input int i);
      int          num;
      logic [63:0] mag;
      logic [63:0] ax;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] top;
      logic [63:0] v;
      num = 2 * i + 1 - entries;
      mag = 64'((num < 0) ? -num : num);
      ax  = udiv64(mag * 64'(SIG_HALF_RANGE) * EXP_ONE, 64'(entries));
      e   = exp_neg_q30(ax);
      den = EXP_ONE + e;
      top = (num >= 0) ? EXP_ONE : e;
      v   = udiv64((top << frac_bits) + (den >> 1), den);
      return v[SIG_VAL_W-1:0];
   endfunction

endpackage

// ===== rtl/mtts_norm.sv =====
// Sensor reading normalization: clamp to full scale and map to a Q1.F activation.
module mtts_norm #(
   parameter int FRAC_BITS = 12
) (
   input  logic [mtts_pkg::READING_W-1:0] reading,
   output logic [FRAC_BITS:0]             act
);
   import mtts_pkg::*;

   localparam int ACT_W = FRAC_BITS + 1;

   logic [NORM_IDX_W-1:0] read_clip;
   logic [ACT_W-1:0]      norm_rom [NORM_FULL_SCALE+1];

   // Build reading*2^F/100 for every reading up to full scale
   for (genvar g = 0; g <= NORM_FULL_SCALE; g++) begin : g_norm
      localparam logic [ACT_W-1:0] V = ACT_W'((g << FRAC_BITS) / NORM_FULL_SCALE);
      assign norm_rom[g] = V;
   end

   // Saturate readings above full scale
   assign read_clip = (reading > READING_W'(NORM_FULL_SCALE)) ?
                      NORM_IDX_W'(NORM_FULL_SCALE) : reading[NORM_IDX_W-1:0];

   assign act = norm_rom[read_clip];

endmodule

// ===== rtl/mtts_sigmoid.sv =====
// Two-stage sigmoid: clamp the net sum to a table index, then registered table read.
module mtts_sigmoid #(
   parameter int ENTRIES   = 256,
   parameter int FRAC_BITS = 12
) (
   input  logic                                          clock,
   input  mtts_pkg::sig_en_type                          en,
   input  logic signed [FRAC_BITS+mtts_pkg::ACC_GUARD-1:0] acc,
   output logic [FRAC_BITS:0]                            act
);
   import mtts_pkg::*;

   localparam int ACC_W  = FRAC_BITS + ACC_GUARD;
   localparam int ACT_W  = FRAC_BITS + 1;
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int DIV_SH = 2 * FRAC_BITS + 4;
   localparam int SH_W   = ((ACC_W > DIV_SH) ? ACC_W : DIV_SH) + 1;
   localparam int NUM_W  = $clog2(ENTRIES + 1);
   localparam int MUL_W  = SH_W + NUM_W;
   localparam int Q_W    = MUL_W - DIV_SH;
   localparam logic signed [SH_W-1:0] OFFSET = SH_W'({1'b1, {(DIV_SH-1){1'b0}}});

   logic signed [SH_W-1:0]  shifted;
   logic [MUL_W-1:0]        scaled;
   logic [Q_W-1:0]          quot;
   logic [IDX_W-1:0]        idx_in;
   logic [IDX_W-1:0]        idx_ff;
   logic [ACT_W-1:0]        act_ff;
   logic [ACT_W-1:0]        sig_rom [ENTRIES];

   // Fill the table with sigmoid values at bin centers over [-8,8)
   for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
      localparam logic [SIG_VAL_W-1:0] V = sigmoid_entry(ENTRIES, FRAC_BITS, g);
      assign sig_rom[g] = ACT_W'(V);
   end

   // Move the net sum to [0,16), scale by the entry count, drop the fraction
   assign shifted = SH_W'(acc) + OFFSET;
   assign scaled  = MUL_W'($unsigned(shifted)) * MUL_W'(ENTRIES);
   assign quot    = scaled[MUL_W-1:DIV_SH];

   // Clamp below to the first entry and above to the last
   always_comb begin
      if (shifted[SH_W-1]) begin
         idx_in = '0;
      end else if (quot >= Q_W'(ENTRIES)) begin
         idx_in = IDX_W'(ENTRIES - 1);
      end else begin
         idx_in = quot[IDX_W-1:0];
      end
   end

   // Index register, then registered table read
   always_ff @(posedge clock) begin
      if (en.idx_en) begin
         idx_ff <= idx_in;
      end
      if (en.rom_en) begin
         act_ff <= sig_rom[idx_ff];
      end
   end

   assign act = act_ff;

endmodule

// ===== rtl/mtts_pipe_ctrl.sv =====
// Valid bits and per-stage ready chain for the datapath pipeline.
module mtts_pipe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    out_ready,
   output logic                    in_ready,
   output mtts_pkg::pipe_ctrl_type ctrl
);
   import mtts_pkg::*;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] upstream;
   logic [STAGES:0]   rdy;

   // A stage can load when it is empty or its content moves on
   assign rdy[STAGES] = out_ready;
   for (genvar k = 0; k < STAGES; k++) begin : g_rdy
      assign rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   // Advance valid bits where a stage loads, hold them where it stalls
   assign upstream = {vld_ff[STAGES-2:0], in_valid};
   assign vld_in   = (rdy[STAGES-1:0] & upstream) | (~rdy[STAGES-1:0] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready = rdy[0];
   assign ctrl.en  = rdy[STAGES-1:0];
   assign ctrl.vld = vld_ff;

   // An accepted beat occupies the first stage next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> vld_ff[0])
      else $error("accepted beat missing from first stage");

   // A result appears only out of the stage before it
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(vld_ff[STAGES-1]) |-> $past(vld_ff[STAGES-2]))
      else $error("result valid without a beat in the previous stage");

   // An empty pipeline always takes a beat
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (vld_ff == '0) |-> in_ready)
      else $error("empty pipeline not ready");

endmodule

// ===== rtl/mlp_two_three_two_sigmoid_forward_unit.sv =====
// Top level of the pipelined 2-3-2 sigmoid MLP forward pass with weight registers.
// Throughput: one beat per cycle; a stalled result holds only the stages behind it.
// Requests pass through ten register stages on their way to the response:
//   normalize, hidden multiply, hidden sum, hidden table index, hidden table read,
//   output multiply, output sum, output table index, output table read, drive scaling.
// Reset (synchronous, active high) clears all valid bits and all weight registers to zero.
module mlp_two_three_two_sigmoid_forward_unit #(
   parameter int SIGMOID_TABLE_ENTRIES = 256,
   parameter int WEIGHT_FRAC_BITS      = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mtts_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mtts_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mtts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mtts_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mtts_pkg::*;

   localparam int F      = WEIGHT_FRAC_BITS;
   localparam int ACT_W  = F + 1;
   localparam int PROD_W = ACT_W + 1 + FIELD_W;
   localparam int ACC_W  = F + ACC_GUARD;
   localparam int SCL_W  = ACT_W + DRIVE_W;

   pipe_ctrl_type           ctrl;
   sig_en_type              hid_sig_en;
   sig_en_type              out_sig_en;

   logic [HID_REG_W-1:0]    hid_w_ff [HIDDEN_COUNT];
   logic [OUT_REG_W-1:0]    out_w_ff [OUTPUT_COUNT];

   logic [ACT_W-1:0]        x_in  [INPUT_COUNT];
   logic [ACT_W-1:0]        x_ff  [INPUT_COUNT];
   logic signed [PROD_W-1:0] hprod_in [HIDDEN_COUNT][INPUT_COUNT];
   logic signed [PROD_W-1:0] hprod_ff [HIDDEN_COUNT][INPUT_COUNT];
   logic signed [ACC_W-1:0] hacc_in [HIDDEN_COUNT];
   logic signed [ACC_W-1:0] hacc_ff [HIDDEN_COUNT];
   logic [ACT_W-1:0]        hid_act [HIDDEN_COUNT];
   logic signed [PROD_W-1:0] oprod_in [OUTPUT_COUNT][HIDDEN_COUNT];
   logic signed [PROD_W-1:0] oprod_ff [OUTPUT_COUNT][HIDDEN_COUNT];
   logic signed [ACC_W-1:0] oacc_in [OUTPUT_COUNT];
   logic signed [ACC_W-1:0] oacc_ff [OUTPUT_COUNT];
   logic [ACT_W-1:0]        out_act [OUTPUT_COUNT];
   logic [SCL_W-1:0]        scaled  [OUTPUT_COUNT];
   logic [DRIVE_W-1:0]      drive_in [OUTPUT_COUNT];
   rsp_type                 rsp_in;
   rsp_type                 rsp_data_ff;

   // Weight registers: writes beyond the register list are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < HIDDEN_COUNT; j++) begin
            hid_w_ff[j] <= '0;
         end
         for (int j = 0; j < OUTPUT_COUNT; j++) begin
            out_w_ff[j] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HIDDEN_ONE: begin
               hid_w_ff[0] <= csr_data[HID_REG_W-1:0];
            end
            CSR_HIDDEN_TWO: begin
               hid_w_ff[1] <= csr_data[HID_REG_W-1:0];
            end
            CSR_HIDDEN_THREE: begin
               hid_w_ff[2] <= csr_data[HID_REG_W-1:0];
            end
            CSR_OUT_LEFT: begin
               out_w_ff[0] <= csr_data[OUT_REG_W-1:0];
            end
            CSR_OUT_RIGHT: begin
               out_w_ff[1] <= csr_data[OUT_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Pipeline control
   mtts_pipe_ctrl u_pipe_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_ready (rsp_ready),
      .in_ready  (req_ready),
      .ctrl      (ctrl)
   );

   // Normalize the two readings
   mtts_norm #(.FRAC_BITS(F)) u_norm_left (
      .reading (req_data.left_reading),
      .act     (x_in[0])
   );

   mtts_norm #(.FRAC_BITS(F)) u_norm_right (
      .reading (req_data.right_reading),
      .act     (x_in[1])
   );

   // Hidden layer: one multiplier per weight, then sum with the bias
   for (genvar j = 0; j < HIDDEN_COUNT; j++) begin : g_hidden
      for (genvar k = 0; k < INPUT_COUNT; k++) begin : g_mul
         assign hprod_in[j][k] = $signed({1'b0, x_ff[k]}) *
                                 $signed(hid_w_ff[j][FIELD_W*k +: FIELD_W]);
      end
      assign hacc_in[j] = ACC_W'(hprod_ff[j][0]) + ACC_W'(hprod_ff[j][1]) +
                          ACC_W'($signed({hid_w_ff[j][FIELD_W*INPUT_COUNT +: FIELD_W],
                                          {F{1'b0}}}));

      mtts_sigmoid #(.ENTRIES(SIGMOID_TABLE_ENTRIES), .FRAC_BITS(F)) u_sig (
         .clock (clock),
         .en    (hid_sig_en),
         .acc   (hacc_ff[j]),
         .act   (hid_act[j])
      );
   end

   assign hid_sig_en.idx_en = ctrl.en[STG_HID_IDX];
   assign hid_sig_en.rom_en = ctrl.en[STG_HID_ROM];

   // Output layer: three weights and a bias per neuron
   for (genvar j = 0; j < OUTPUT_COUNT; j++) begin : g_output
      for (genvar k = 0; k < HIDDEN_COUNT; k++) begin : g_mul
         assign oprod_in[j][k] = $signed({1'b0, hid_act[k]}) *
                                 $signed(out_w_ff[j][FIELD_W*k +: FIELD_W]);
      end
      assign oacc_in[j] = ACC_W'(oprod_ff[j][0]) + ACC_W'(oprod_ff[j][1]) +
                          ACC_W'(oprod_ff[j][2]) +
                          ACC_W'($signed({out_w_ff[j][FIELD_W*HIDDEN_COUNT +: FIELD_W],
                                          {F{1'b0}}}));

      mtts_sigmoid #(.ENTRIES(SIGMOID_TABLE_ENTRIES), .FRAC_BITS(F)) u_sig (
         .clock (clock),
         .en    (out_sig_en),
         .acc   (oacc_ff[j]),
         .act   (out_act[j])
      );

      // Scale by 255 as x*256 - x, drop the fraction, saturate
      assign scaled[j]   = {out_act[j], {DRIVE_W{1'b0}}} - SCL_W'(out_act[j]);
      assign drive_in[j] = (scaled[j][SCL_W-1:F] > (SCL_W-F)'(DRIVE_MAX)) ?
                           DRIVE_W'(DRIVE_MAX) : scaled[j][F+DRIVE_W-1:F];
   end

   assign out_sig_en.idx_en = ctrl.en[STG_OUT_IDX];
   assign out_sig_en.rom_en = ctrl.en[STG_OUT_ROM];

   assign rsp_in.left_drive  = drive_in[0];
   assign rsp_in.right_drive = drive_in[1];

   // Datapath registers, each loaded when its stage advances
   always_ff @(posedge clock) begin
      if (ctrl.en[STG_NORM]) begin
         x_ff <= x_in;
      end
      if (ctrl.en[STG_HID_PROD]) begin
         hprod_ff <= hprod_in;
      end
      if (ctrl.en[STG_HID_ACC]) begin
         hacc_ff <= hacc_in;
      end
      if (ctrl.en[STG_OUT_PROD]) begin
         oprod_ff <= oprod_in;
      end
      if (ctrl.en[STG_OUT_ACC]) begin
         oacc_ff <= oacc_in;
      end
      if (ctrl.en[STG_DRIVE]) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = ctrl.vld[STG_DRIVE];
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== verif/mlp_two_three_two_sigmoid_forward_unit_test.sv =====
// Self-checking testbench for the pipelined 2-3-2 sigmoid perceptron forward unit.
module mlp_two_three_two_sigmoid_forward_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mtts_pkg::*;

   localparam int TABLE_N     = 256;
   localparam int FRAC        = 12;
   localparam int PIPE_DEPTH  = 10;
   localparam int CYCLE_LIMIT = 300000;

   localparam logic [CSR_IDX_W-1:0] REG_ORDER [5] = '{
      CSR_HIDDEN_ONE, CSR_HIDDEN_TWO, CSR_HIDDEN_THREE, CSR_OUT_LEFT, CSR_OUT_RIGHT
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Mirror of the weight registers and the sigmoid curve
   logic [HID_REG_W-1:0]  hidden_regs [3];
   logic [OUT_REG_W-1:0]  out_regs    [2];
   longint                sigmoid_curve [TABLE_N];

   rsp_type               expected_drives [$];
   int                    fault_count  = 0;
   int unsigned           cycle_count  = 0;
   int                    send_odds    = 0;
   int                    stall_odds   = 0;
   int                    stall_left   = 0;

   mlp_two_three_two_sigmoid_forward_unit #(
      .SIGMOID_TABLE_ENTRIES(TABLE_N),
      .WEIGHT_FRAC_BITS     (FRAC)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always #1 clock = ~clock;

   // Sigmoid at the center of bin i: Taylor series of e^-(x/16), squared four times
   function automatic longint curve_point(int i);
      longint unsigned one_q;
      longint unsigned mag;
      longint unsigned ax;
      longint unsigned y;
      longint unsigned term;
      longint unsigned decay;
      longint unsigned den;
      longint unsigned top;
      int              num;
      one_q = 64'd1 << 30;
      num   = 2 * i + 1 - TABLE_N;
      mag   = (num < 0) ? -num : num;
      ax    = (mag * 8 * one_q) / TABLE_N;
      y     = ax >> 4;
      term  = one_q;
      decay = one_q;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * y) >> 30) / k;
         if (k % 2 == 1) begin
            decay = (decay >= term) ? decay - term : 0;
         end else begin
            decay = decay + term;
         end
      end
      if (decay > one_q) begin
         decay = one_q;
      end
      repeat (4) decay = (decay * decay) >> 30;
      den = one_q + decay;
      top = (num >= 0) ? one_q : decay;
      return longint'(((top << FRAC) + den / 2) / den);
   endfunction

   // Signed 16-bit field k of a packed weight register
   function automatic longint weight(logic [63:0] word, int k);
      logic [15:0] f;
      f = word[16*k +: 16];
      return longint'($signed(f));
   endfunction

   // Reading to activation, saturating at full scale
   function automatic longint level(logic [READING_W-1:0] r);
      longint v;
      v = (r > NORM_FULL_SCALE) ? NORM_FULL_SCALE : r;
      return (v << FRAC) / NORM_FULL_SCALE;
   endfunction

   // Table lookup with clamping to the end entries outside [-8,8)
   function automatic longint squash(longint net);
      longint shifted;
      longint idx;
      shifted = net + (longint'(8) << (2 * FRAC));
      if (shifted < 0) begin
         return sigmoid_curve[0];
      end
      idx = (shifted * TABLE_N) / ((longint'(1) << (2 * FRAC)) * 16);
      if (idx >= TABLE_N) begin
         idx = TABLE_N - 1;
      end
      return sigmoid_curve[idx];
   endfunction

   // Full forward pass over the mirrored weights
   function automatic rsp_type forward_pass(req_type item);
      longint  lvl [2];
      longint  act [3];
      longint  net;
      longint  drv [2];
      rsp_type r;
      lvl[0] = level(item.left_reading);
      lvl[1] = level(item.right_reading);
      for (int n = 0; n < 3; n++) begin
         net = lvl[0] * weight(hidden_regs[n], 0) + lvl[1] * weight(hidden_regs[n], 1)
             + (weight(hidden_regs[n], 2) <<< FRAC);
         act[n] = squash(net);
      end
      for (int o = 0; o < 2; o++) begin
         net = act[0] * weight(out_regs[o], 0) + act[1] * weight(out_regs[o], 1)
             + act[2] * weight(out_regs[o], 2) + (weight(out_regs[o], 3) <<< FRAC);
         drv[o] = (squash(net) * DRIVE_MAX) >>> FRAC;
         if (drv[o] > DRIVE_MAX) begin
            drv[o] = DRIVE_MAX;
         end
      end
      r.left_drive  = drv[0][DRIVE_W-1:0];
      r.right_drive = drv[1][DRIVE_W-1:0];
      return r;
   endfunction

   // Track register writes, predict on each request beat, check each response beat
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HIDDEN_ONE:   hidden_regs[0] = csr_data[HID_REG_W-1:0];
               CSR_HIDDEN_TWO:   hidden_regs[1] = csr_data[HID_REG_W-1:0];
               CSR_HIDDEN_THREE: hidden_regs[2] = csr_data[HID_REG_W-1:0];
               CSR_OUT_LEFT:     out_regs[0]    = csr_data;
               CSR_OUT_RIGHT:    out_regs[1]    = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_drives.push_back(forward_pass(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               $error("rsp beat with nothing expected: left_drive %0d right_drive %0d",
                      rsp_data.left_drive, rsp_data.right_drive);
               fault_count++;
            end else begin
               want = expected_drives.pop_front();
               if (rsp_data.left_drive !== want.left_drive) begin
                  $error("left_drive expected %0d actual %0d",
                         want.left_drive, rsp_data.left_drive);
                  fault_count++;
               end
               if (rsp_data.right_drive !== want.right_drive) begin
                  $error("right_drive expected %0d actual %0d",
                         want.right_drive, rsp_data.right_drive);
                  fault_count++;
               end
            end
         end
      end
   end

   // Drop rsp_ready in random bursts of random length
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("mlp_two_three_two_sigmoid_forward_unit test failed");
         $finish;
      end
   end

   // Present one request beat, hold it until accepted, then maybe idle
   task automatic send_reading(logic [READING_W-1:0] left, logic [READING_W-1:0] right);
      int gap;
      req_valid              <= 1'b1;
      req_data.left_reading  <= left;
      req_data.right_reading <= right;
      do @(posedge clock); while (!req_ready);
      gap = (send_odds != 0 && $urandom_range(1, send_odds) == 1) ? $urandom_range(1, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Close the request stream and wait for every response
   task automatic finish_stream();
      req_valid <= 1'b0;
      // Let the checker log the last accepted beat first
      @(posedge clock);
      while (expected_drives.size() != 0) @(posedge clock);
   endtask

   // One csr beat; valid stays high so beats can go back to back
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Load all five weight registers
   task automatic load_network(logic [CSR_DATA_W-1:0] regs [5]);
      for (int r = 0; r < 5; r++) begin
         write_csr(REG_ORDER[r], regs[r]);
      end
      csr_valid <= 1'b0;
   endtask

   // Same 16-bit value in every field; junk above the hidden register width
   task automatic load_uniform(logic [15:0] hid_field, logic [15:0] out_field);
      logic [CSR_DATA_W-1:0] regs [5];
      for (int r = 0; r < 5; r++) begin
         regs[r] = (r < 3) ? {16'($urandom_range(0, 65535)), {3{hid_field}}} : {4{out_field}};
      end
      load_network(regs);
   endtask

   function automatic logic [15:0] random_field(int bits);
      int v;
      v = $urandom_range(0, (1 << bits) - 1) - (1 << (bits - 1));
      return v[15:0];
   endfunction

   function automatic logic [READING_W-1:0] random_reading();
      case ($urandom_range(0, 3))
         0:       return READING_W'($urandom_range(0, NORM_FULL_SCALE));
         1:       return READING_W'($urandom_range(NORM_FULL_SCALE - 5, NORM_FULL_SCALE + 5));
         default: return READING_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Zero weights after reset: every neuron sits at the table middle
   task automatic test_reset_weights();
      send_reading(8'd0, 8'd0);
      send_reading(8'd255, 8'd255);
      send_reading(8'd100, 8'd50);
      finish_stream();
   endtask

   // Largest weights drive the nets past both ends of the table
   task automatic test_extreme_weights();
      logic [15:0] hid_set [3];
      logic [15:0] out_set [3];
      hid_set = '{16'h7FFF, 16'h8000, 16'h7FFF};
      out_set = '{16'h7FFF, 16'h8000, 16'h8000};
      for (int s = 0; s < 3; s++) begin
         load_uniform(hid_set[s], out_set[s]);
         send_reading(8'd0, 8'd0);
         send_reading(8'd100, 8'd100);
         send_reading(8'd101, 8'd255);
         send_reading(8'd255, 8'd99);
         finish_stream();
      end
   endtask

   // Writes to indexes past the register list leave the weights alone
   task automatic test_ignored_writes();
      load_uniform(16'h0800, 16'hF800);
      for (int s = CSR_OUT_RIGHT + 1; s < (1 << CSR_IDX_W); s++) begin
         write_csr(s[CSR_IDX_W-1:0], {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
      send_reading(8'd0, 8'd255);
      send_reading(8'd50, 8'd25);
      send_reading(8'd255, 8'd0);
      send_reading(8'd75, 8'd100);
      finish_stream();
   endtask

   // Random networks and readings under one idling profile
   task automatic test_random_phase(int beats, int weight_bits, int s_odds, int r_odds);
      logic [CSR_DATA_W-1:0] regs [5];
      for (int r = 0; r < 5; r++) begin
         regs[r] = {random_field(16), random_field(weight_bits), random_field(weight_bits),
                    random_field(weight_bits)};
         if (r >= 3) begin
            regs[r][63:48] = random_field(weight_bits);
         end
      end
      load_network(regs);
      send_odds  = s_odds;
      stall_odds = r_odds;
      repeat (beats) send_reading(random_reading(), random_reading());
      finish_stream();
   endtask

   initial begin
      for (int i = 0; i < TABLE_N; i++) begin
         sigmoid_curve[i] = curve_point(i);
      end
      hidden_regs = '{default: '0};
      out_regs    = '{default: '0};
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_weights();
      test_extreme_weights();
      test_ignored_writes();
      test_random_phase(180, 16, 3, 4);
      test_random_phase(180, 14, 0, 3);
      test_random_phase(180, 13, 4, 0);
      test_random_phase(180, 12, 2, 2);
      test_random_phase(180, 15, 8, 8);
      // Closing stretch runs back to back with no idling
      test_random_phase(120, 14, 0, 0);

      repeat (PIPE_DEPTH + 5) @(posedge clock);
      if (expected_drives.size() != 0) begin
         $error("%0d expected rsp beats never arrived", expected_drives.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("mlp_two_three_two_sigmoid_forward_unit test passed");
      end else begin
         $display("mlp_two_three_two_sigmoid_forward_unit test failed");
      end
      $finish;
   end

endmodule
